[sv/stb_pkg.sv]
// Shared codes, widths and control/status types for the software timer bank.
package stb_pkg;

	// Default sizing of the bank
	localparam int TIMER_COUNT_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	// Field widths of one input item and one result item
	localparam int FUNC_W  = 3;
	localparam int ID_W    = 4;
	localparam int TICKS_W = 32;
	localparam int MODE_W  = 2;
	localparam int KIND_W  = 2;

	// Stream packing widths
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 8;

	// Command codes
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;

	// Timer modes
	localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture the input item
		logic rd_en;      // read count/period memories
		logic rd_walk;    // read address: 1 walk pointer, 0 item id
		logic walk_init;  // point the walk at timer 1
		logic walk_step;  // advance the walk pointer
		logic tick_upd;   // decrement or reload the visited timer
		logic ev_take;    // hold the visited timer as pending expiry
		logic ev_push;    // send the pending expiry to the output
		logic ev_last;    // mark the pushed expiry as final
		logic ev_clr;     // drop the pending expiry
		logic exec;       // run allocate/start/stop/query and answer
	} stb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              walk_more;  // walk pointer below allocated count
		logic              run;        // visited timer is running
		logic              expire;     // visited count is about to reach zero
		logic              pend_valid; // an expiry is held back
		logic              out_free;   // output register can take an item
	} stb_status_t;

endpackage

[sv/stb_datapath.sv]
// Timer storage, walk pointer, pending expiry and output register of the timer bank.
module stb_datapath #(
	parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEF,
	parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stb_pkg::stb_cmd_t             cmd,
	output stb_pkg::stb_status_t          status,
	input  logic [stb_pkg::FUNC_W-1:0]    in_func,
	input  logic [stb_pkg::ID_W-1:0]      in_timer_id,
	input  logic [stb_pkg::TICKS_W-1:0]   in_ticks,
	input  logic [stb_pkg::MODE_W-1:0]    in_mode,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [stb_pkg::KIND_W-1:0]    out_kind,
	output logic [stb_pkg::ID_W-1:0]      out_result_id,
	output logic                          out_flag,
	output logic                          out_last
);

	localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int AW = $clog2(TIMER_COUNT + 1);
	localparam int XW = AW + stb_pkg::ID_W;
	localparam int CW = COUNT_WIDTH;

	// Captured input item
	logic [stb_pkg::FUNC_W-1:0]  func_q;
	logic [stb_pkg::ID_W-1:0]    id_q;
	logic [stb_pkg::TICKS_W-1:0] ticks_q;
	logic [stb_pkg::MODE_W-1:0]  mode_q;

	// Control state
	logic [AW-1:0]          alloc_q;
	logic [AW-1:0]          walk_q;
	logic [TIMER_COUNT-1:0] run_q;
	logic [TIMER_COUNT-1:0] modeb_q;
	logic [TIMER_COUNT-1:0] cvalid_q;
	logic                   pend_valid_q;
	logic [stb_pkg::ID_W-1:0] pend_id_q;

	// Timer memories and their read registers
	logic [CW-1:0] count_mem_q  [TIMER_COUNT];
	logic [CW-1:0] period_mem_q [TIMER_COUNT];
	logic [CW-1:0] cnt_rd_q;
	logic [CW-1:0] per_rd_q;
	logic          cval_rd_q;

	// Output register
	logic                       out_valid_q;
	logic [stb_pkg::KIND_W-1:0] out_kind_q;
	logic [stb_pkg::ID_W-1:0]   out_id_q;
	logic                       out_flag_q;
	logic                       out_last_q;

	// Derived values
	logic [XW-1:0]             id_x;
	logic [XW-1:0]             walk_x;
	logic [XW-1:0]             alloc_x;
	logic [IW-1:0]             id_idx;
	logic [IW-1:0]             walk_idx;
	logic [IW-1:0]             rd_idx;
	logic                      id_in_range;
	logic                      start_ok;
	logic                      bank_full;
	logic [CW+stb_pkg::TICKS_W-1:0] ticks_x;
	logic [CW-1:0]             ticks_cw;
	logic [CW-1:0]             count_eff;
	logic [CW-1:0]             count_dec;
	logic                      expire;
	logic                      out_free;

	assign id_x        = {{AW{1'b0}}, id_q};
	assign walk_x      = {{stb_pkg::ID_W{1'b0}}, walk_q};
	assign alloc_x     = {{stb_pkg::ID_W{1'b0}}, alloc_q};
	assign id_idx      = id_x[IW-1:0];
	assign walk_idx    = walk_x[IW-1:0];
	assign rd_idx      = cmd.rd_walk ? walk_idx : id_idx;
	assign id_in_range = id_x < XW'(TIMER_COUNT);
	assign start_ok    = id_in_range && (id_x < alloc_x) &&
	                     (mode_q == stb_pkg::MODE_SINGLE || mode_q == stb_pkg::MODE_PERIODIC);
	assign bank_full   = alloc_q >= AW'(TIMER_COUNT);
	assign ticks_x     = {{CW{1'b0}}, ticks_q};
	assign ticks_cw    = ticks_x[CW-1:0];
	assign count_eff   = cval_rd_q ? cnt_rd_q : '0;
	assign count_dec   = count_eff - CW'(1);
	assign expire      = count_eff == CW'(1);
	assign out_free    = !out_valid_q || out_ready;

	// Report status to the controller
	assign status.func       = func_q;
	assign status.walk_more  = walk_q < alloc_q;
	assign status.run        = run_q[walk_idx];
	assign status.expire     = expire;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	// Capture the input item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_func;
			id_q    <= in_timer_id;
			ticks_q <= in_ticks;
			mode_q  <= in_mode;
		end
	end

	// Read and write the count and period memories
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			cnt_rd_q <= count_mem_q[rd_idx];
			per_rd_q <= period_mem_q[rd_idx];
		end
		if (cmd.tick_upd) begin
			count_mem_q[walk_idx] <= expire ? per_rd_q : count_dec;
		end else if (cmd.exec && func_q == stb_pkg::FUNC_START && start_ok) begin
			count_mem_q[id_idx]  <= ticks_cw;
			period_mem_q[id_idx] <= ticks_cw;
		end
	end

	// Track valid, running and mode bits, allocation and the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q      <= AW'(1);
			walk_q       <= '0;
			run_q        <= '0;
			modeb_q      <= '0;
			cvalid_q     <= '0;
			cval_rd_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
		end else begin
			if (cmd.rd_en) begin
				cval_rd_q <= cvalid_q[rd_idx];
			end
			if (cmd.walk_init) begin
				walk_q <= AW'(1);
			end else if (cmd.walk_step) begin
				walk_q <= walk_q + AW'(1);
			end
			if (cmd.tick_upd) begin
				cvalid_q[walk_idx] <= 1'b1;
				if (expire && !modeb_q[walk_idx]) begin
					run_q[walk_idx] <= 1'b0;
				end
			end
			if (cmd.exec) begin
				case (func_q)
					stb_pkg::FUNC_ALLOC: begin
						if (!bank_full) begin
							alloc_q <= alloc_q + AW'(1);
						end
					end
					stb_pkg::FUNC_START: begin
						if (start_ok) begin
							cvalid_q[id_idx] <= 1'b1;
							modeb_q[id_idx]  <= mode_q[0];
							run_q[id_idx]    <= 1'b1;
						end
					end
					stb_pkg::FUNC_STOP: begin
						if (id_in_range) begin
							run_q[id_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			// Hold back the newest expiry until the next one or the end of the walk
			if (cmd.ev_take) begin
				pend_valid_q <= 1'b1;
				pend_id_q    <= walk_x[stb_pkg::ID_W-1:0];
			end else if (cmd.ev_clr) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register, drop the item once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec || cmd.ev_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_last_q <= 1'b1;
			out_id_q   <= '0;
			case (func_q)
				stb_pkg::FUNC_ALLOC: begin
					out_kind_q <= stb_pkg::KIND_ALLOC;
					out_flag_q <= !bank_full;
					out_id_q   <= bank_full ? '0 : alloc_x[stb_pkg::ID_W-1:0];
				end
				stb_pkg::FUNC_START: begin
					out_kind_q <= stb_pkg::KIND_ACK;
					out_flag_q <= start_ok;
				end
				stb_pkg::FUNC_QUERY: begin
					out_kind_q <= stb_pkg::KIND_QUERY;
					out_flag_q <= id_in_range && (count_eff == '0);
				end
				default: begin
					out_kind_q <= stb_pkg::KIND_ACK;
					out_flag_q <= 1'b1;
				end
			endcase
		end else if (cmd.ev_push) begin
			out_kind_q <= stb_pkg::KIND_EXPIRY;
			out_id_q   <= pend_id_q;
			out_flag_q <= 1'b1;
			out_last_q <= cmd.ev_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_kind      = out_kind_q;
	assign out_result_id = out_id_q;
	assign out_flag      = out_flag_q;
	assign out_last      = out_last_q;

	// A result is never written over one still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.ev_push) |-> out_free)
		else $error("result pushed while output register is occupied");

	// Allocation count stays within 1 .. TIMER_COUNT
	a_alloc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(alloc_q != '0) && (alloc_q <= AW'(TIMER_COUNT)))
		else $error("allocation count out of range");

	// Tick updates only touch allocated, non-reserved timers
	a_upd_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_upd |-> (walk_q < alloc_q) && (walk_q != '0))
		else $error("tick update outside allocated timers");

	// A taken expiry is pending in the next cycle
	a_pend_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_take |=> pend_valid_q)
		else $error("expiry lost after take");

endmodule

[sv/stb_ctrl.sv]
// Command sequencer of the timer bank: decodes items and walks the timers on a tick.
module stb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  stb_pkg::stb_status_t status,
	output stb_pkg::stb_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_RESP   = 3'd2;
	localparam logic [2:0] S_WCHK   = 3'd3;
	localparam logic [2:0] S_WEXE   = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = state_q == S_IDLE;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.func) inside
					stb_pkg::FUNC_TICK: begin
						cmd.walk_init = 1'b1;
						state_d       = S_WCHK;
					end
					stb_pkg::FUNC_ALLOC, stb_pkg::FUNC_START, stb_pkg::FUNC_STOP: begin
						state_d = S_RESP;
					end
					stb_pkg::FUNC_QUERY: begin
						cmd.rd_en = 1'b1;
						state_d   = S_RESP;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_RESP: begin
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_WCHK: begin
				if (status.walk_more) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_walk = 1'b1;
					state_d     = S_WEXE;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_WEXE: begin
				if (!status.run) begin
					cmd.walk_step = 1'b1;
					state_d       = S_WCHK;
				end else if (!status.expire) begin
					cmd.tick_upd  = 1'b1;
					cmd.walk_step = 1'b1;
					state_d       = S_WCHK;
				end else if (!status.pend_valid || status.out_free) begin
					// Release the older expiry, hold this one back
					cmd.tick_upd  = 1'b1;
					cmd.walk_step = 1'b1;
					cmd.ev_take   = 1'b1;
					cmd.ev_push   = status.pend_valid;
					state_d       = S_WCHK;
				end
			end
			S_FLUSH: begin
				if (!status.pend_valid) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.ev_push = 1'b1;
					cmd.ev_last = 1'b1;
					cmd.ev_clr  = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/software_timer_bank_core.sv]
// Top level of the software timer bank: stream ports, controller and datapath.
//
// Input stream (s_*): one command item per handshake: tick, allocate, start,
// stop or query. Output stream (m_*): the result items of each command; the
// final result of a command carries m_tlast. Allocate, start, stop and query
// give exactly one result; a tick gives one expiry per timer that reaches
// zero, in rising id order, and none if no timer expires; unknown commands
// give none.
// Flow: allocate, start and stop pass from acceptance through decode to a
// response state that writes the result; query also reads the memory in
// decode. A tick visits timers 1 .. allocated-1, each with a registered
// memory read, then update; the next item is accepted once the current
// one has handed its last result to the output register.
// Reset: all timers stopped, counts zero, only timer 0 (reserved) taken.
// Stall: a held output register (m_tready low) halts the walk or response
// until the waiting result is taken; no result is dropped.
module software_timer_bank_core #(
	parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEF,
	parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [stb_pkg::S_DATA_W-1:0]  s_tdata,  // func[2:0], timer_id[6:3], ticks[38:7], mode[40:39]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [stb_pkg::M_DATA_W-1:0]  m_tdata,  // result_id[3:0], flag[4]
	output logic [stb_pkg::KIND_W-1:0]    m_tuser,  // kind[1:0]
	output logic                          m_tlast   // last
);

	stb_pkg::stb_cmd_t    cmd;
	stb_pkg::stb_status_t status;

	logic [stb_pkg::ID_W-1:0] result_id;
	logic                     flag;

	stb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	stb_datapath #(
		.TIMER_COUNT (TIMER_COUNT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_func       (s_tdata[2:0]),
		.in_timer_id   (s_tdata[6:3]),
		.in_ticks      (s_tdata[38:7]),
		.in_mode       (s_tdata[40:39]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_kind      (m_tuser),
		.out_result_id (result_id),
		.out_flag      (flag),
		.out_last      (m_tlast)
	);

	// Pack the result fields
	assign m_tdata = {3'b000, flag, result_id};

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the software timer bank: commands in, expiries and answers out.
`timescale 1ns / 1ps

module tb_top;

	// Commands outside the defined set, and modes that start must refuse
	localparam logic [stb_pkg::FUNC_W-1:0] FUNC_BAD_FIRST = 3'd5;
	localparam logic [stb_pkg::FUNC_W-1:0] FUNC_BAD_LAST  = 3'd7;
	localparam logic [stb_pkg::MODE_W-1:0] MODE_BAD_LO    = 2'd2;
	localparam logic [stb_pkg::MODE_W-1:0] MODE_BAD_HI    = 2'd3;
	localparam int               BANK_SIZE      = stb_pkg::TIMER_COUNT_DEF;
	localparam int               RANDOM_ITEMS   = 84;
	localparam int               DRAIN_CYCLES   = 2 * BANK_SIZE + 32;

	typedef struct {
		logic [stb_pkg::FUNC_W-1:0]  func;
		logic [stb_pkg::ID_W-1:0]    id;
		logic [stb_pkg::TICKS_W-1:0] ticks;
		logic [stb_pkg::MODE_W-1:0]  mode;
		int                          phase;
	} timer_cmd_t;

	typedef struct {
		logic [stb_pkg::KIND_W-1:0] kind;
		logic [stb_pkg::ID_W-1:0]   id;
		logic                       flag;
		logic                       last;
	} timer_reply_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [stb_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [stb_pkg::M_DATA_W-1:0]   m_tdata;
	logic [stb_pkg::KIND_W-1:0]     m_tuser;
	logic                           m_tlast;

	timer_cmd_t   cmd_queue[$];
	timer_cmd_t   on_bus;
	timer_reply_t awaited_replies[$];
	int           live_phase = 0;
	int           fail_count = 0;

	// Shadow copy of the bank
	logic [stb_pkg::COUNT_WIDTH_DEF-1:0] bank_period [BANK_SIZE];
	logic [stb_pkg::COUNT_WIDTH_DEF-1:0] bank_count  [BANK_SIZE];
	logic                                bank_periodic [BANK_SIZE];
	logic                                bank_running  [BANK_SIZE];
	int                                  next_free_id;

	software_timer_bank_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic timer_reply_t make_reply(logic [stb_pkg::KIND_W-1:0] kind, int id,
			logic flag, logic last);
		timer_reply_t r;
		r.kind = kind;
		r.id   = id[stb_pkg::ID_W-1:0];
		r.flag = flag;
		r.last = last;
		return r;
	endfunction

	// Idle or stall decision for the current phase; rx selects the receiving side
	function automatic bit idle_now(int ph, bit rx);
		int rate;
		rate = 0;
		if (ph == 1 && !rx)
			rate = 51;
		else if (ph == 2 && rx)
			rate = 51;
		else if (ph == 3)
			rate = 16;
		return $urandom_range(0, 99) < rate;
	endfunction

	// Advance the shadow bank by one command and queue the replies it causes
	function automatic void apply_command(timer_cmd_t c);
		timer_reply_t batch[$];
		int k;
		case (c.func)
			stb_pkg::FUNC_TICK: begin
				for (k = 1; k < next_free_id && k < BANK_SIZE; k++) begin
					if (bank_running[k]) begin
						bank_count[k] = bank_count[k] - 1'b1;
						if (bank_count[k] == '0) begin
							batch.push_back(make_reply(stb_pkg::KIND_EXPIRY, k, 1'b1, 1'b0));
							bank_count[k] = bank_period[k];
							if (!bank_periodic[k])
								bank_running[k] = 1'b0;
						end
					end
				end
				if (batch.size() != 0)
					batch[batch.size() - 1].last = 1'b1;
				foreach (batch[i])
					awaited_replies.push_back(batch[i]);
			end
			stb_pkg::FUNC_ALLOC: begin
				if (next_free_id >= BANK_SIZE) begin
					awaited_replies.push_back(make_reply(stb_pkg::KIND_ALLOC, 0, 1'b0, 1'b1));
				end else begin
					awaited_replies.push_back(make_reply(stb_pkg::KIND_ALLOC, next_free_id,
						1'b1, 1'b1));
					next_free_id++;
				end
			end
			stb_pkg::FUNC_START: begin
				if (int'(c.id) < next_free_id && c.mode < MODE_BAD_LO) begin
					bank_period[c.id]   = c.ticks;
					bank_count[c.id]    = c.ticks;
					bank_periodic[c.id] = (c.mode == stb_pkg::MODE_PERIODIC);
					bank_running[c.id]  = 1'b1;
					awaited_replies.push_back(make_reply(stb_pkg::KIND_ACK, 0, 1'b1, 1'b1));
				end else begin
					awaited_replies.push_back(make_reply(stb_pkg::KIND_ACK, 0, 1'b0, 1'b1));
				end
			end
			stb_pkg::FUNC_STOP: begin
				bank_running[c.id] = 1'b0;
				awaited_replies.push_back(make_reply(stb_pkg::KIND_ACK, 0, 1'b1, 1'b1));
			end
			stb_pkg::FUNC_QUERY: begin
				awaited_replies.push_back(make_reply(stb_pkg::KIND_QUERY, 0,
					bank_count[c.id] == '0, 1'b1));
			end
			default: begin
			end
		endcase
	endfunction

	task automatic push_cmd(logic [stb_pkg::FUNC_W-1:0] func, int id,
			logic [stb_pkg::TICKS_W-1:0] ticks, logic [stb_pkg::MODE_W-1:0] mode, int ph);
		timer_cmd_t c;
		c.func  = func;
		c.id    = id[stb_pkg::ID_W-1:0];
		c.ticks = ticks;
		c.mode  = mode;
		c.phase = ph;
		cmd_queue.push_back(c);
	endtask

	// Driver: present queued items, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_command(on_bus);
				live_phase <= on_bus.phase;
			end
			if (!s_tvalid || s_tready) begin
				if (cmd_queue.size() != 0 && !idle_now(cmd_queue[0].phase, 1'b0)) begin
					on_bus = cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, on_bus.mode, on_bus.ticks, on_bus.id, on_bus.func};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest awaited reply
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin : take_result
				timer_reply_t want;
				if (awaited_replies.size() == 0) begin
					$error("result with no reply awaited: kind %0d id %0d flag %0d last %0d",
						m_tuser, m_tdata[3:0], m_tdata[4], m_tlast);
					fail_count++;
				end else begin
					want = awaited_replies.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata[3:0] !== want.id) begin
						$error("result_id: expected %0d, got %0d", want.id, m_tdata[3:0]);
						fail_count++;
					end
					if (m_tdata[4] !== want.flag) begin
						$error("flag: expected %0d, got %0d", want.flag, m_tdata[4]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			m_tready <= !idle_now(live_phase, 1'b1);
		end
	end

	// Main sequence: reset, fill the command queue, wait for the replies to drain
	initial begin : main_seq
		int counted;
		int gen_alloc;
		int pick;
		int ph;
		int id;
		int top_id;
		logic [31:0]                 rnd;
		logic [stb_pkg::FUNC_W-1:0]  func;
		logic [stb_pkg::TICKS_W-1:0] ticks;
		logic [stb_pkg::MODE_W-1:0]  mode;

		for (int i = 0; i < BANK_SIZE; i++) begin
			bank_period[i]   = '0;
			bank_count[i]    = '0;
			bank_periodic[i] = 1'b0;
			bank_running[i]  = 1'b0;
		end
		next_free_id = 1;

		// Directed part: refusals, reserved id, zero period, multi-expiry, unknown codes
		push_cmd(stb_pkg::FUNC_QUERY, 0, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_TICK, 15, '1, MODE_BAD_HI, 0);
		push_cmd(stb_pkg::FUNC_ALLOC, 0, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_ALLOC, 0, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_ALLOC, 0, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_START, 5, 32'd3, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_START, 1, 32'd3, MODE_BAD_LO, 0);
		push_cmd(stb_pkg::FUNC_START, 1, 32'd3, MODE_BAD_HI, 0);
		push_cmd(stb_pkg::FUNC_START, 0, 32'd7, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_START, 1, 32'd1, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_START, 2, 32'd2, stb_pkg::MODE_PERIODIC, 0);
		push_cmd(stb_pkg::FUNC_START, 3, 32'd0, stb_pkg::MODE_PERIODIC, 0);
		push_cmd(stb_pkg::FUNC_QUERY, 1, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_TICK, 0, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_TICK, 0, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_QUERY, 15, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_STOP, 9, '0, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_STOP, 2, '0, stb_pkg::MODE_SINGLE, 0);
		for (int f = FUNC_BAD_FIRST; f <= FUNC_BAD_LAST; f++)
			push_cmd(f[stb_pkg::FUNC_W-1:0], 10, 32'hA5A5_5A5A, stb_pkg::MODE_PERIODIC, 0);
		push_cmd(stb_pkg::FUNC_START, 3, 32'hFFFF_FFFF, stb_pkg::MODE_PERIODIC, 0);
		push_cmd(stb_pkg::FUNC_START, 1, 32'd1, stb_pkg::MODE_SINGLE, 0);
		push_cmd(stb_pkg::FUNC_START, 2, 32'd1, stb_pkg::MODE_PERIODIC, 0);
		push_cmd(stb_pkg::FUNC_TICK, 0, '0, stb_pkg::MODE_SINGLE, 0);
		gen_alloc = 4;

		// Random part: mostly allocate, start small periods and tick, with some noise
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			ph    = (counted * 4) / RANDOM_ITEMS;
			pick  = $urandom_range(0, 99);
			id    = $urandom_range(0, BANK_SIZE - 1);
			ticks = $urandom();
			rnd   = $urandom_range(0, 3);
			mode  = rnd[stb_pkg::MODE_W-1:0];
			if (pick < 35) begin
				func = stb_pkg::FUNC_TICK;
			end else if (pick < 53) begin
				func = stb_pkg::FUNC_ALLOC;
				gen_alloc++;
			end else if (pick < 78) begin
				func = stb_pkg::FUNC_START;
				top_id = (gen_alloc > BANK_SIZE - 1) ? BANK_SIZE - 1 : gen_alloc;
				if ($urandom_range(0, 99) < 75)
					id = $urandom_range(0, top_id);
				pick = $urandom_range(0, 99);
				if (pick < 60)
					ticks = $urandom_range(1, 4);
				else if (pick < 75)
					ticks = $urandom_range(5, 20);
				else if (pick < 85)
					ticks = '0;
				else if (pick < 90)
					ticks = '1;
				if ($urandom_range(0, 99) < 85) begin
					rnd  = $urandom_range(stb_pkg::MODE_SINGLE, stb_pkg::MODE_PERIODIC);
					mode = rnd[stb_pkg::MODE_W-1:0];
				end
			end else if (pick < 86) begin
				func = stb_pkg::FUNC_STOP;
			end else if (pick < 96) begin
				func = stb_pkg::FUNC_QUERY;
			end else begin
				rnd  = $urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST);
				func = rnd[stb_pkg::FUNC_W-1:0];
			end
			push_cmd(func, id, ticks, mode, ph);
			if (func <= stb_pkg::FUNC_QUERY)
				counted++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && awaited_replies.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Hard stop on a hung run
	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
